// ===== design/ole_pkg.sv =====
// Shared types, sizes and codes for the ordered list engine.
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [3:0] RQ_PREPEND = 4'd0;
  localparam logic [3:0] RQ_APPEND = 4'd1;
  localparam logic [3:0] RQ_INSERT_AT = 4'd2;
  localparam logic [3:0] RQ_FIND_FIRST = 4'd3;
  localparam logic [3:0] RQ_FIND_LAST = 4'd4;
  localparam logic [3:0] RQ_READ_FIRST = 4'd5;
  localparam logic [3:0] RQ_READ_LAST = 4'd6;
  localparam logic [3:0] RQ_POP_FIRST = 4'd7;
  localparam logic [3:0] RQ_POP_LAST = 4'd8;
  localparam logic [3:0] RQ_REMOVE_MATCH = 4'd9;
  localparam logic [3:0] RQ_CLEAR = 4'd10;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_BADPOS = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic signed [31:0] MIN_VALUE = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0] req_type;
    logic [4:0] position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic signed [31:0] result_value;
    logic [3:0] result_index;
    logic [4:0] entry_count;
  } res_t;

  typedef struct packed {
    logic ren;
    logic [ADDR_W-1:0] raddr;
    logic wen;
    logic [ADDR_W-1:0] waddr;
    logic [31:0] wdata;
  } mem_port_t;

endpackage

// ===== design/ole_store.sv =====
// Entry storage: one write port and one registered read port.
module ole_store (
  input  logic clk,
  input  ole_pkg::mem_port_t port,
  output logic [31:0] rdata
);
  import ole_pkg::*;

  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (port.wen) begin
      mem[port.waddr] <= port.wdata;
    end
    if (port.ren) begin
      rdata <= mem[port.raddr];
    end
  end

endmodule

// ===== design/ole_ctrl.sv =====
// Request sequencer that walks the entry storage for shifts and searches.
module ole_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  ole_pkg::req_t request,
  input  logic [31:0] rdata,
  output ole_pkg::mem_port_t mem,
  output logic busy,
  output logic done,
  output ole_pkg::res_t result
);
  import ole_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DOWN = 2'd3;

  logic [1:0] state, state_next;
  logic [3:0] op, op_next;
  logic [31:0] val, val_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] lim, lim_next;
  logic walk, walk_next;
  logic pend, pend_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  logic hit, hit_next;
  logic [ADDR_W-1:0] hidx, hidx_next;
  logic [CNT_W-1:0] count, count_next;
  logic [31:0] rval, rval_next;
  logic done_next;
  res_t result_next;

  logic [POS_W-1:0] ins_pos;
  logic hit_now;
  logic stop;
  logic fin_hit;
  logic [ADDR_W-1:0] fin_idx;
  logic shrink;

  function automatic res_t make_res(input logic [2:0] st, input logic [31:0] v,
                                    input logic [ADDR_W-1:0] idx,
                                    input logic [CNT_W-1:0] cnt);
    res_t r;
    r.status = st;
    r.result_value = v;
    r.result_index = 4'(idx);
    r.entry_count = 5'(cnt);
    return r;
  endfunction

  always_comb begin
    state_next = state;
    op_next = op;
    val_next = val;
    pos_next = pos;
    ptr_next = ptr;
    lim_next = lim;
    walk_next = walk;
    pend_next = pend;
    pend_addr_next = pend_addr;
    hit_next = hit;
    hidx_next = hidx;
    count_next = count;
    rval_next = rval;
    done_next = 1'b0;
    result_next = result;
    mem = '0;
    ins_pos = '0;
    hit_now = 1'b0;
    stop = 1'b0;
    fin_hit = 1'b0;
    fin_idx = '0;
    shrink = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next = request.req_type;
          val_next = request.value;
          walk_next = 1'b0;
          pend_next = 1'b0;
          hit_next = 1'b0;
          case (request.req_type)
            RQ_PREPEND, RQ_APPEND, RQ_INSERT_AT: begin
              if (request.req_type == RQ_PREPEND) begin
                ins_pos = '0;
              end else if (request.req_type == RQ_APPEND) begin
                ins_pos = POS_W'(count);
              end else begin
                ins_pos = POS_W'(request.position);
              end
              if (ins_pos > POS_W'(count)) begin
                done_next = 1'b1;
                result_next = make_res(ST_BADPOS, '0, '0, count);
              end else if (count == CNT_W'(CAPACITY)) begin
                done_next = 1'b1;
                result_next = make_res(ST_FULL, '0, '0, count);
              end else begin
                pos_next = ADDR_W'(ins_pos);
                if (ins_pos != POS_W'(count)) begin
                  walk_next = 1'b1;
                  ptr_next = ADDR_W'(count - 1'b1);
                end
                state_next = S_UP;
              end
            end
            RQ_FIND_FIRST, RQ_FIND_LAST, RQ_REMOVE_MATCH: begin
              if (count == '0) begin
                done_next = 1'b1;
                if (request.req_type == RQ_REMOVE_MATCH) begin
                  result_next = make_res(ST_EMPTY, MIN_VALUE, '0, count);
                end else begin
                  result_next = make_res(ST_MISSING, '0, '0, count);
                end
              end else begin
                ptr_next = '0;
                lim_next = ADDR_W'(count - 1'b1);
                walk_next = 1'b1;
                state_next = S_SCAN;
              end
            end
            RQ_READ_FIRST, RQ_READ_LAST, RQ_POP_FIRST, RQ_POP_LAST: begin
              if (count == '0) begin
                done_next = 1'b1;
                result_next = make_res(ST_EMPTY, MIN_VALUE, '0, count);
              end else begin
                if (request.req_type == RQ_READ_FIRST || request.req_type == RQ_POP_FIRST) begin
                  pos_next = '0;
                end else begin
                  pos_next = ADDR_W'(count - 1'b1);
                end
                ptr_next = pos_next;
                if (request.req_type == RQ_READ_FIRST || request.req_type == RQ_READ_LAST) begin
                  lim_next = pos_next;
                end else begin
                  lim_next = ADDR_W'(count - 1'b1);
                end
                walk_next = 1'b1;
                state_next = S_DOWN;
              end
            end
            RQ_CLEAR: begin
              count_next = '0;
              done_next = 1'b1;
              result_next = make_res(ST_OK, '0, '0, '0);
            end
            default: begin
              done_next = 1'b1;
              result_next = make_res(ST_OK, '0, '0, count);
            end
          endcase
        end
      end

      S_UP: begin
        mem.wen = pend;
        mem.waddr = pend_addr + 1'b1;
        mem.wdata = rdata;
        if (walk) begin
          mem.ren = 1'b1;
          mem.raddr = ptr;
          pend_next = 1'b1;
          pend_addr_next = ptr;
          if (ptr == pos) begin
            walk_next = 1'b0;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end else begin
          pend_next = 1'b0;
        end
        if (!walk && !pend) begin
          mem.wen = 1'b1;
          mem.waddr = pos;
          mem.wdata = val;
          count_next = count + 1'b1;
          done_next = 1'b1;
          result_next = make_res(ST_OK, '0, '0, count_next);
          state_next = S_IDLE;
        end
      end

      S_SCAN: begin
        if (walk) begin
          mem.ren = 1'b1;
          mem.raddr = ptr;
          pend_next = 1'b1;
          pend_addr_next = ptr;
          if (ptr == lim) begin
            walk_next = 1'b0;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end else begin
          pend_next = 1'b0;
        end
        hit_now = pend && (rdata == val);
        if (hit_now) begin
          hit_next = 1'b1;
          hidx_next = pend_addr;
        end
        stop = (hit_now && op != RQ_FIND_LAST) || (!walk && !pend);
        if (stop) begin
          walk_next = 1'b0;
          pend_next = 1'b0;
          fin_hit = hit || hit_now;
          fin_idx = hit_now ? pend_addr : hidx;
          if (!fin_hit) begin
            done_next = 1'b1;
            result_next = make_res(ST_MISSING, '0, '0, count);
            state_next = S_IDLE;
          end else if (op == RQ_REMOVE_MATCH) begin
            pos_next = fin_idx;
            ptr_next = fin_idx;
            lim_next = ADDR_W'(count - 1'b1);
            walk_next = 1'b1;
            state_next = S_DOWN;
          end else begin
            done_next = 1'b1;
            result_next = make_res(ST_OK, '0, fin_idx, count);
            state_next = S_IDLE;
          end
        end
      end

      S_DOWN: begin
        if (walk) begin
          mem.ren = 1'b1;
          mem.raddr = ptr;
          pend_next = 1'b1;
          pend_addr_next = ptr;
          if (ptr == lim) begin
            walk_next = 1'b0;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if (pend_addr == pos) begin
            rval_next = rdata;
          end else begin
            mem.wen = 1'b1;
            mem.waddr = pend_addr - 1'b1;
            mem.wdata = rdata;
          end
        end
        if (!walk && !pend) begin
          shrink = (op == RQ_POP_FIRST) || (op == RQ_POP_LAST) || (op == RQ_REMOVE_MATCH);
          if (shrink) begin
            count_next = count - 1'b1;
          end
          done_next = 1'b1;
          result_next = make_res(ST_OK, rval, pos, count_next);
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      walk <= 1'b0;
      pend <= 1'b0;
      hit <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      walk <= walk_next;
      pend <= pend_next;
      hit <= hit_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    val <= val_next;
    pos <= pos_next;
    ptr <= ptr_next;
    lim <= lim_next;
    pend_addr <= pend_addr_next;
    hidx <= hidx_next;
    rval <= rval_next;
    result <= result_next;
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== design/ordered_list_engine.sv =====
// Top level of the ordered list engine: sequencer, entry storage and checks.
//
//   channel   signals                      transfer happens when
//   request   start, busy, request         start high and busy low at a clock edge
//   result    done, result                 done high; held one cycle, never stalled
//
// Clear, unused codes, empty-list and rejected inserts answer from idle. Inserts
// shift the entries from the position to the end up by one, then write the
// new value; reads and pops walk in the down state; a first-match find stops at
// the match, a miss or last-match find scans every entry and a match removal
// scans, then shifts down; the single storage port moves one entry per cycle.
// Synchronous reset empties the list; entries are never cleared.
module ordered_list_engine (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  ole_pkg::req_t request,
  output logic busy,
  output logic done,
  output ole_pkg::res_t result
);
  import ole_pkg::*;

  mem_port_t mem;
  logic [31:0] rdata;

  ole_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .rdata(rdata),
    .mem(mem),
    .busy(busy),
    .done(done),
    .result(result)
  );

  ole_store u_store (
    .clk(clk),
    .port(mem),
    .rdata(rdata)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe while a request is still in progress.");

  a_start_answered: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("Accepted request neither started nor answered.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> result.entry_count <= 5'(CAPACITY))
    else $error("Entry count above capacity.");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_EMPTY |-> result.result_value == MIN_VALUE)
    else $error("Empty status without the minimum value.");

endmodule
